// ===== sv/adab_pkg.sv =====
// Shared types, operation codes, microprogram and fp32 helpers for the AdaBelief update block.
// Used by adab_fpu and adabelief_param_update; depends on nothing else.
package adab_pkg;

  localparam logic [31:0] FP_ONE      = 32'h3F80_0000;
  localparam logic [31:0] FP_DNAN     = 32'hFFC0_0000;
  localparam logic [31:0] FP_QBIT     = 32'h0040_0000;
  localparam logic [31:0] BETA1_RESET = 32'h3F66_6666;
  localparam logic [31:0] BETA2_RESET = 32'h3F7F_BE77;
  localparam logic [31:0] ETA_RESET   = 32'h38D1_B717;
  localparam logic [31:0] EPS_RESET   = 32'h322B_CC77;

  localparam logic [1:0] CFG_BETA1 = 2'd0;
  localparam logic [1:0] CFG_BETA2 = 2'd1;
  localparam logic [1:0] CFG_ETA   = 2'd2;
  localparam logic [1:0] CFG_EPS   = 2'd3;

  localparam logic [4:0] UPC_MAIN = 5'd2;
  localparam logic [4:0] UPC_LAST = 5'd22;

  typedef enum logic [2:0] {
    FOP_ADD,
    FOP_SUB,
    FOP_MUL,
    FOP_DIV,
    FOP_SQRT
  } fop_t;

  typedef enum logic [4:0] {
    SRC_ONE, SRC_B1, SRC_B2, SRC_ETA, SRC_EPS, SRC_P1, SRC_P2,
    SRC_G, SRC_X, SRC_M, SRC_S,
    SRC_W0, SRC_W1, SRC_W2, SRC_W3, SRC_W4, SRC_W5, SRC_W6, SRC_W7
  } opnd_t;

  typedef struct packed {
    fop_t  op;
    opnd_t a;
    opnd_t b;
    opnd_t dst;
  } uop_t;

  // Steps 0 and 1 advance the beta powers; the update proper starts at UPC_MAIN.
  // The new moment ends in W4, the new second moment in W6 and the new parameter in W7.
  function automatic uop_t uop_at(input logic [4:0] pc);
    uop_t u;
    u = '{FOP_ADD, SRC_ONE, SRC_ONE, SRC_W0};
    case (pc)
      5'd0:  u = '{FOP_MUL,  SRC_P1,  SRC_B1,  SRC_P1};
      5'd1:  u = '{FOP_MUL,  SRC_P2,  SRC_B2,  SRC_P2};
      5'd2:  u = '{FOP_SUB,  SRC_ONE, SRC_P1,  SRC_W0};
      5'd3:  u = '{FOP_DIV,  SRC_ONE, SRC_W0,  SRC_W0};
      5'd4:  u = '{FOP_SUB,  SRC_ONE, SRC_P2,  SRC_W1};
      5'd5:  u = '{FOP_DIV,  SRC_ONE, SRC_W1,  SRC_W1};
      5'd6:  u = '{FOP_SUB,  SRC_ONE, SRC_B1,  SRC_W2};
      5'd7:  u = '{FOP_SUB,  SRC_ONE, SRC_B2,  SRC_W3};
      5'd8:  u = '{FOP_MUL,  SRC_B1,  SRC_M,   SRC_W4};
      5'd9:  u = '{FOP_MUL,  SRC_W2,  SRC_G,   SRC_W5};
      5'd10: u = '{FOP_SUB,  SRC_W4,  SRC_W5,  SRC_W4};
      5'd11: u = '{FOP_MUL,  SRC_W4,  SRC_W0,  SRC_W0};
      5'd12: u = '{FOP_ADD,  SRC_G,   SRC_W4,  SRC_W5};
      5'd13: u = '{FOP_MUL,  SRC_B2,  SRC_S,   SRC_W6};
      5'd14: u = '{FOP_MUL,  SRC_W3,  SRC_W5,  SRC_W7};
      5'd15: u = '{FOP_MUL,  SRC_W7,  SRC_W5,  SRC_W7};
      5'd16: u = '{FOP_ADD,  SRC_W6,  SRC_W7,  SRC_W6};
      5'd17: u = '{FOP_MUL,  SRC_W6,  SRC_W1,  SRC_W1};
      5'd18: u = '{FOP_SQRT, SRC_W1,  SRC_ONE, SRC_W1};
      5'd19: u = '{FOP_ADD,  SRC_W1,  SRC_EPS, SRC_W1};
      5'd20: u = '{FOP_DIV,  SRC_ETA, SRC_W1,  SRC_W1};
      5'd21: u = '{FOP_MUL,  SRC_W1,  SRC_W0,  SRC_W1};
      5'd22: u = '{FOP_SUB,  SRC_X,   SRC_W1,  SRC_W7};
      default: u = '{FOP_ADD, SRC_ONE, SRC_ONE, SRC_W0};
    endcase
    return u;
  endfunction

  function automatic logic [5:0] lzc48(input logic [47:0] x);
    logic [5:0] cnt;
    cnt = 6'd48;
    for (int i = 0; i < 48; i++) begin
      if (x[i]) cnt = 6'(47 - i);
    end
    return cnt;
  endfunction

  // Rounds to nearest even. mant[26] carries the leading one, mant[0] is sticky.
  function automatic logic [31:0] round_pack(input logic sgn, input logic signed [11:0] e,
                                             input logic [26:0] mant);
    logic [26:0] m;
    logic [26:0] back;
    logic [4:0] sh;
    logic [7:0] ef;
    logic inc;
    logic [30:0] pk;
    logic signed [11:0] shs;
    m = mant;
    ef = e[7:0];
    back = '0;
    sh = '0;
    shs = 12'sd1 - e;
    if (e >= 12'sd255) return {sgn, 8'hFF, 23'd0};
    if (e <= 12'sd0) begin
      ef = 8'd0;
      if (shs >= 12'sd27) begin
        m = {26'd0, |mant};
      end else begin
        sh = shs[4:0];
        m = mant >> sh;
        back = m << sh;
        m[0] = m[0] | (back != mant);
      end
    end
    inc = m[2] & (m[3] | m[1] | m[0]);
    pk = {ef, m[25:3]} + 31'(inc);
    return {sgn, pk};
  endfunction

endpackage

// ===== sv/adab_ram.sv =====
// Single-port-write, single-port-read memory with registered read data.
// Stands alone; instantiated three times by adabelief_param_update.
module adab_ram #(
  parameter int DEPTH = 4096,
  parameter int AW = 12
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [31:0]   wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [31:0]   rdata
);

  logic [31:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/adab_fpu.sv =====
// Shared fp32 unit: add, subtract and multiply round in a finish state, divide and
// square root work one bit a cycle. Depends on adab_pkg.
module adab_fpu (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  adab_pkg::fop_t     op,
  input  logic [31:0]        a,
  input  logic [31:0]        b,
  output logic               done,
  output logic [31:0]        result
);
  import adab_pkg::*;

  typedef enum logic [1:0] {F_IDLE, F_ITER, F_FIN} fstate_t;

  fstate_t state;
  fop_t op_r;
  logic sign_r;
  logic signed [11:0] e_r;
  logic [47:0] prod_r;
  logic [27:0] sum_r;
  logic [23:0] nb_r;
  logic [24:0] rem_r;
  logic [27:0] quo_r;
  logic [47:0] sq_n, sq_res, sq_bit;
  logic [4:0] cnt;

  logic sa, sb, sbe, nan_a, nan_b, inf_a, inf_b, zero_a, zero_b;
  logic [7:0] exa, exb;
  logic [8:0] ea, eb;
  logic [23:0] ma, mb;
  logic spec;
  logic [31:0] spec_val;
  logic swap, eff_sub, sign_big;
  logic [8:0] e_big, e_small, dexp;
  logic [23:0] m_big, m_small;
  logic [27:0] bx, bal, bback, sum_c;
  logic [5:0] lza, lzb;
  logic [23:0] na, nbn;
  logic signed [11:0] sq_e;
  logic [24:0] sq_m;
  logic [47:0] trial;
  logic [24:0] rem_sub;
  logic [5:0] lz_fin;
  logic [47:0] norm48;
  logic [27:0] norm28;
  logic [47:0] sq_r;
  logic signed [11:0] e_fin;
  logic [31:0] fin_val;

  always_comb begin
    sa = a[31];
    sb = b[31];
    sbe = b[31] ^ (op == FOP_SUB);
    exa = a[30:23];
    exb = b[30:23];
    nan_a = (exa == 8'hFF) && (a[22:0] != 23'd0);
    nan_b = (exb == 8'hFF) && (b[22:0] != 23'd0);
    inf_a = (exa == 8'hFF) && (a[22:0] == 23'd0);
    inf_b = (exb == 8'hFF) && (b[22:0] == 23'd0);
    zero_a = (a[30:0] == 31'd0);
    zero_b = (b[30:0] == 31'd0);
    ea = (exa == 8'd0) ? 9'd1 : {1'b0, exa};
    eb = (exb == 8'd0) ? 9'd1 : {1'b0, exb};
    ma = {exa != 8'd0, a[22:0]};
    mb = {exb != 8'd0, b[22:0]};
    spec = 1'b1;
    spec_val = FP_DNAN;
    unique case (op)
      FOP_ADD, FOP_SUB: begin
        if (nan_a) spec_val = a | FP_QBIT;
        else if (nan_b) spec_val = b | FP_QBIT;
        else if (inf_a && inf_b && (sa != sbe)) spec_val = FP_DNAN;
        else if (inf_a) spec_val = a;
        else if (inf_b) spec_val = {sbe, b[30:0]};
        else if (zero_a && zero_b) spec_val = {sa & sbe, 31'd0};
        else if (zero_a) spec_val = {sbe, b[30:0]};
        else if (zero_b) spec_val = a;
        else spec = 1'b0;
      end
      FOP_MUL: begin
        if (nan_a) spec_val = a | FP_QBIT;
        else if (nan_b) spec_val = b | FP_QBIT;
        else if ((inf_a && zero_b) || (zero_a && inf_b)) spec_val = FP_DNAN;
        else if (inf_a || inf_b) spec_val = {sa ^ sb, 8'hFF, 23'd0};
        else if (zero_a || zero_b) spec_val = {sa ^ sb, 31'd0};
        else spec = 1'b0;
      end
      FOP_DIV: begin
        if (nan_a) spec_val = a | FP_QBIT;
        else if (nan_b) spec_val = b | FP_QBIT;
        else if ((inf_a && inf_b) || (zero_a && zero_b)) spec_val = FP_DNAN;
        else if (inf_a || zero_b) spec_val = {sa ^ sb, 8'hFF, 23'd0};
        else if (inf_b || zero_a) spec_val = {sa ^ sb, 31'd0};
        else spec = 1'b0;
      end
      FOP_SQRT: begin
        if (nan_a) spec_val = a | FP_QBIT;
        else if (zero_a) spec_val = a;
        else if (sa) spec_val = FP_DNAN;
        else if (inf_a) spec_val = a;
        else spec = 1'b0;
      end
      default: spec_val = FP_DNAN;
    endcase

    swap = b[30:0] > a[30:0];
    e_big = swap ? eb : ea;
    e_small = swap ? ea : eb;
    m_big = swap ? mb : ma;
    m_small = swap ? ma : mb;
    sign_big = swap ? sbe : sa;
    eff_sub = sa ^ sbe;
    dexp = e_big - e_small;
    bx = {1'b0, m_small, 3'b000};
    bal = '0;
    bback = '0;
    if (dexp >= 9'd28) begin
      bal = 28'd1;
    end else begin
      bal = bx >> dexp;
      bback = bal << dexp;
      bal[0] = bal[0] | (bback != bx);
    end
    sum_c = eff_sub ? ({1'b0, m_big, 3'b000} - bal) : ({1'b0, m_big, 3'b000} + bal);

    lza = lzc48({ma, 1'b1, 23'd0});
    lzb = lzc48({mb, 1'b1, 23'd0});
    na = ma << lza;
    nbn = mb << lzb;

    sq_m = {1'b0, ma << lza};
    sq_e = (exa == 8'd0) ? (-12'sd126 - 12'(lza)) : (12'(exa) - 12'sd127);
    if (sq_e[0]) begin
      sq_m = sq_m << 1;
      sq_e = sq_e - 12'sd1;
    end

    trial = sq_res + sq_bit;
    rem_sub = rem_r - {1'b0, nb_r};

    lz_fin = '0;
    norm48 = '0;
    norm28 = '0;
    sq_r = '0;
    e_fin = e_r;
    fin_val = '0;
    unique case (op_r)
      FOP_MUL: begin
        lz_fin = lzc48(prod_r);
        norm48 = prod_r << lz_fin;
        e_fin = e_r - 12'(lz_fin);
        fin_val = round_pack(sign_r, e_fin, {norm48[47:22], |norm48[21:0]});
      end
      FOP_ADD, FOP_SUB: begin
        lz_fin = lzc48({sum_r, 20'd0});
        norm28 = sum_r << lz_fin;
        e_fin = e_r - 12'(lz_fin);
        if (sum_r == 28'd0) fin_val = 32'd0;
        else fin_val = round_pack(sign_r, e_fin, {norm28[27:2], |norm28[1:0]});
      end
      FOP_DIV: begin
        if (quo_r[27]) begin
          fin_val = round_pack(sign_r, e_r,
                               {quo_r[27:2], |quo_r[1:0] | (rem_r != 25'd0)});
        end else begin
          e_fin = e_r - 12'sd1;
          fin_val = round_pack(sign_r, e_fin, {quo_r[26:1], quo_r[0] | (rem_r != 25'd0)});
        end
      end
      FOP_SQRT: begin
        sq_r = sq_res + 48'(sq_n > sq_res);
        if (sq_r[24]) begin
          sq_r = sq_r >> 1;
          e_fin = e_r + 12'sd1;
        end
        fin_val = {1'b0, e_fin[7:0], sq_r[22:0]};
      end
      default: fin_val = FP_DNAN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
      done <= 1'b0;
      op_r <= FOP_ADD;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        F_IDLE: begin
          if (start) begin
            op_r <= op;
            if (spec) begin
              result <= spec_val;
              done <= 1'b1;
            end else begin
              unique case (op)
                FOP_MUL: begin
                  sign_r <= sa ^ sb;
                  prod_r <= 48'(ma) * 48'(mb);
                  e_r <= 12'(ea) + 12'(eb) - 12'sd126;
                  state <= F_FIN;
                end
                FOP_DIV: begin
                  sign_r <= sa ^ sb;
                  nb_r <= nbn;
                  rem_r <= {1'b0, na};
                  quo_r <= '0;
                  e_r <= (12'(ea) - 12'(lza)) - (12'(eb) - 12'(lzb)) + 12'sd127;
                  cnt <= 5'd27;
                  state <= F_ITER;
                end
                FOP_SQRT: begin
                  sq_n <= 48'(sq_m) << 23;
                  sq_res <= '0;
                  sq_bit <= 48'd1 << 46;
                  e_r <= (sq_e >>> 1) + 12'sd127;
                  cnt <= 5'd23;
                  state <= F_ITER;
                end
                default: begin
                  sign_r <= sign_big;
                  sum_r <= sum_c;
                  e_r <= 12'(e_big) + 12'sd1;
                  state <= F_FIN;
                end
              endcase
            end
          end
        end
        F_ITER: begin
          if (op_r == FOP_DIV) begin
            if (rem_r >= {1'b0, nb_r}) begin
              quo_r <= {quo_r[26:0], 1'b1};
              rem_r <= {rem_sub[23:0], 1'b0};
            end else begin
              quo_r <= {quo_r[26:0], 1'b0};
              rem_r <= {rem_r[23:0], 1'b0};
            end
          end else begin
            if (sq_n >= trial) begin
              sq_n <= sq_n - trial;
              sq_res <= (sq_res >> 1) + sq_bit;
            end else begin
              sq_res <= sq_res >> 1;
            end
            sq_bit <= sq_bit >> 2;
          end
          cnt <= cnt - 5'd1;
          if (cnt == 5'd0) state <= F_FIN;
        end
        F_FIN: begin
          result <= fin_val;
          done <= 1'b1;
          state <= F_IDLE;
        end
        default: state <= F_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) done |-> state == F_IDLE)
    else $error("fpu done outside idle");
  assert property (@(posedge clk) disable iff (rst) state == F_FIN |=> done)
    else $error("fpu finish without done");
  assert property (@(posedge clk) disable iff (rst)
                   (state == F_ITER && op_r == FOP_SQRT) |-> $onehot(sq_bit))
    else $error("sqrt bit lost");

endmodule

// ===== sv/adabelief_param_update.sv =====
// AdaBelief parameter update, fp32. Depends on adab_pkg, adab_ram and adab_fpu.
// After reset the block clears every entry of its three stores, one entry a cycle, with busy
// high. A word is taken when start is high and busy low, and busy stays high until its
// result appears on out_index and param_bits for one cycle with done; the receiver cannot
// stall it. A load goes straight to the write state. An update runs 21 operations in sequence
// on one shared fp32 unit (23 with the power advance); an index out of range is not updated
// and returns zero. Configuration writes are taken at any time.
module adabelief_param_update #(
  parameter int NUM_VARS = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        mode,
  input  logic [11:0] elem_index,
  input  logic [31:0] grad_bits,
  input  logic        first_of_step,
  input  logic [31:0] load_param_bits,
  input  logic [31:0] load_first_bits,
  input  logic [31:0] load_second_bits,
  output logic        done,
  output logic [11:0] out_index,
  output logic [31:0] param_bits,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import adab_pkg::*;

  localparam int AW = (NUM_VARS > 1) ? $clog2(NUM_VARS) : 1;

  typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_ISSUE, S_WAIT, S_WRITE} state_t;

  state_t state;
  logic [AW-1:0] clr_addr;
  logic [31:0] beta1_bits, beta2_bits, learn_rate_bits, stabilizer_bits;
  logic [31:0] p1, p2;
  logic [31:0] w0, w1, w2, w3, w4, w5, w6, w7;
  logic it_mode, it_valid;
  logic [11:0] it_index;
  logic [31:0] it_grad, it_lp, it_lm, it_ls;
  logic [4:0] pc;

  logic [31:0] idx_ext, it_ext;
  logic in_range;
  logic [AW-1:0] raddr, waddr;
  logic we, re;
  logic [31:0] wd_x, wd_m, wd_s;
  logic [31:0] rd_x, rd_m, rd_s;
  uop_t uop;
  logic [31:0] opa, opb;
  logic fpu_start, fpu_done;
  logic [31:0] fpu_res;

  function automatic logic [31:0] pick(input opnd_t c, input logic [31:0] b1, b2, eta, eps,
                                       pw1, pw2, g, x, m, s, r0, r1, r2, r3, r4, r5, r6, r7);
    logic [31:0] v;
    unique case (c)
      SRC_ONE: v = FP_ONE;
      SRC_B1:  v = b1;
      SRC_B2:  v = b2;
      SRC_ETA: v = eta;
      SRC_EPS: v = eps;
      SRC_P1:  v = pw1;
      SRC_P2:  v = pw2;
      SRC_G:   v = g;
      SRC_X:   v = x;
      SRC_M:   v = m;
      SRC_S:   v = s;
      SRC_W0:  v = r0;
      SRC_W1:  v = r1;
      SRC_W2:  v = r2;
      SRC_W3:  v = r3;
      SRC_W4:  v = r4;
      SRC_W5:  v = r5;
      SRC_W6:  v = r6;
      SRC_W7:  v = r7;
      default: v = '0;
    endcase
    return v;
  endfunction

  assign busy = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign idx_ext = 32'(elem_index);
  assign it_ext = 32'(it_index);
  assign in_range = idx_ext < 32'(NUM_VARS);
  assign raddr = idx_ext[AW-1:0];
  assign re = start && !busy;
  assign we = (state == S_CLEAR) || (state == S_WRITE && it_valid);
  assign waddr = (state == S_CLEAR) ? clr_addr : it_ext[AW-1:0];
  assign wd_x = (state == S_CLEAR) ? 32'd0 : (it_mode ? it_lp : w7);
  assign wd_m = (state == S_CLEAR) ? 32'd0 : (it_mode ? it_lm : w4);
  assign wd_s = (state == S_CLEAR) ? 32'd0 : (it_mode ? it_ls : w6);
  assign uop = uop_at(pc);
  assign fpu_start = (state == S_ISSUE);
  assign opa = pick(uop.a, beta1_bits, beta2_bits, learn_rate_bits, stabilizer_bits, p1, p2,
                    it_grad, rd_x, rd_m, rd_s, w0, w1, w2, w3, w4, w5, w6, w7);
  assign opb = pick(uop.b, beta1_bits, beta2_bits, learn_rate_bits, stabilizer_bits, p1, p2,
                    it_grad, rd_x, rd_m, rd_s, w0, w1, w2, w3, w4, w5, w6, w7);

  adab_ram #(.DEPTH(NUM_VARS), .AW(AW)) u_param_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wd_x), .re(re), .raddr(raddr), .rdata(rd_x)
  );
  adab_ram #(.DEPTH(NUM_VARS), .AW(AW)) u_first_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wd_m), .re(re), .raddr(raddr), .rdata(rd_m)
  );
  adab_ram #(.DEPTH(NUM_VARS), .AW(AW)) u_second_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wd_s), .re(re), .raddr(raddr), .rdata(rd_s)
  );

  adab_fpu u_fpu (
    .clk(clk), .rst(rst), .start(fpu_start), .op(uop.op), .a(opa), .b(opb),
    .done(fpu_done), .result(fpu_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_addr <= '0;
      done <= 1'b0;
      pc <= '0;
      p1 <= FP_ONE;
      p2 <= FP_ONE;
      beta1_bits <= BETA1_RESET;
      beta2_bits <= BETA2_RESET;
      learn_rate_bits <= ETA_RESET;
      stabilizer_bits <= EPS_RESET;
    end else begin
      done <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_BETA1: beta1_bits <= cfg_data;
          CFG_BETA2: beta2_bits <= cfg_data;
          CFG_ETA:   learn_rate_bits <= cfg_data;
          CFG_EPS:   stabilizer_bits <= cfg_data;
          default:   beta1_bits <= cfg_data;
        endcase
      end
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == AW'(NUM_VARS - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (start) begin
            it_mode <= mode;
            it_index <= elem_index;
            it_valid <= in_range;
            it_grad <= grad_bits;
            it_lp <= load_param_bits;
            it_lm <= load_first_bits;
            it_ls <= load_second_bits;
            if (mode) begin
              state <= S_WRITE;
            end else if (first_of_step) begin
              pc <= '0;
              state <= S_ISSUE;
            end else if (in_range) begin
              pc <= UPC_MAIN;
              state <= S_ISSUE;
            end else begin
              state <= S_WRITE;
            end
          end
        end
        S_ISSUE: state <= S_WAIT;
        S_WAIT: begin
          if (fpu_done) begin
            unique case (uop.dst)
              SRC_P1: p1 <= fpu_res;
              SRC_P2: p2 <= fpu_res;
              SRC_W0: w0 <= fpu_res;
              SRC_W1: w1 <= fpu_res;
              SRC_W2: w2 <= fpu_res;
              SRC_W3: w3 <= fpu_res;
              SRC_W4: w4 <= fpu_res;
              SRC_W5: w5 <= fpu_res;
              SRC_W6: w6 <= fpu_res;
              SRC_W7: w7 <= fpu_res;
              default: w0 <= fpu_res;
            endcase
            if ((pc == UPC_LAST) || ((pc == UPC_MAIN - 5'd1) && !it_valid)) begin
              state <= S_WRITE;
            end else begin
              pc <= pc + 5'd1;
              state <= S_ISSUE;
            end
          end
        end
        S_WRITE: begin
          done <= 1'b1;
          out_index <= it_index;
          param_bits <= it_valid ? (it_mode ? it_lp : w7) : 32'd0;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result shown while busy");
  assert property (@(posedge clk) disable iff (rst) (start && !busy) |=> busy)
    else $error("accepted word did not start work");
  assert property (@(posedge clk) disable iff (rst) fpu_done |-> state == S_WAIT)
    else $error("fpu result with no operation pending");
  assert property (@(posedge clk) disable iff (rst) we |-> state == S_CLEAR || it_valid)
    else $error("store written for an index out of range");

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for adabelief_param_update: drives load and update words, predicts
// every result with an fp32 model kept in a scoreboard class. Depends on adab_pkg and the RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import adab_pkg::*;

  localparam logic MODE_UPDATE = 1'b0;
  localparam logic MODE_LOAD   = 1'b1;
  localparam int   IDLE_LIMIT  = 20000;

  typedef struct packed {
    logic [11:0] index;
    logic [31:0] value;
  } param_word_t;

  class update_scoreboard;
    logic [31:0] param_mem [4096];
    logic [31:0] first_mem [4096];
    logic [31:0] second_mem [4096];
    logic [31:0] pow1, pow2, beta1, beta2, eta, eps;
    param_word_t pending_q [$];
    int errors;

    function new();
      foreach (param_mem[i]) begin
        param_mem[i] = '0;
        first_mem[i] = '0;
        second_mem[i] = '0;
      end
      pow1 = FP_ONE;
      pow2 = FP_ONE;
      beta1 = BETA1_RESET;
      beta2 = BETA2_RESET;
      eta = ETA_RESET;
      eps = EPS_RESET;
      errors = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] data);
      case (idx)
        CFG_BETA1: beta1 = data;
        CFG_BETA2: beta2 = data;
        CFG_ETA:   eta = data;
        CFG_EPS:   eps = data;
        default: ;
      endcase
    endfunction

    function bit is_nan(logic [31:0] x);
      return x[30:23] == 8'hFF && x[22:0] != 0;
    endfunction

    function bit is_inf(logic [31:0] x);
      return x[30:0] == 31'h7F80_0000;
    endfunction

    function bit is_zero(logic [31:0] x);
      return x[30:0] == 31'd0;
    endfunction

    function void unpack(input logic [31:0] x, output logic [63:0] m, output int e);
      if (x[30:23] == 8'd0) begin
        m = {41'd0, x[22:0]};
        e = -149;
      end else begin
        m = {40'd0, 1'b1, x[22:0]};
        e = int'(x[30:23]) - 150;
      end
    endfunction

    // Value is sig * 2^e; bit 0 of sig may carry a sticky bit well below the rounding point.
    function logic [31:0] round_f32(logic sgn, logic [63:0] sig, int e);
      int p, sh, eq, biased;
      logic [63:0] kept;
      logic half, low;
      if (sig == 0) return {sgn, 31'd0};
      p = 0;
      for (int i = 0; i < 64; i++) begin
        if (sig[i]) p = i;
      end
      sh = p - 23;
      if (-149 - e > sh) sh = -149 - e;
      if (sh > 64) begin
        kept = 0;
      end else if (sh > 0) begin
        kept = sig >> sh;
        half = sig[sh - 1];
        low = (sig & ((64'd1 << (sh - 1)) - 64'd1)) != 0;
        if (half && (low || kept[0])) kept = kept + 64'd1;
      end else begin
        kept = sig << (-sh);
      end
      eq = e + sh;
      if (kept[24]) begin
        kept = kept >> 1;
        eq++;
      end
      if (!kept[23]) return {sgn, 8'd0, kept[22:0]};
      biased = eq + 150;
      if (biased >= 255) return {sgn, 8'hFF, 23'd0};
      return {sgn, 8'(biased), kept[22:0]};
    endfunction

    function logic [31:0] fp_mul(logic [31:0] a, logic [31:0] b);
      logic [63:0] ma, mb;
      int ea, eb;
      logic s;
      if (is_nan(a)) return a | FP_QBIT;
      if (is_nan(b)) return b | FP_QBIT;
      s = a[31] ^ b[31];
      if ((is_inf(a) && is_zero(b)) || (is_inf(b) && is_zero(a))) return FP_DNAN;
      if (is_inf(a) || is_inf(b)) return {s, 8'hFF, 23'd0};
      if (is_zero(a) || is_zero(b)) return {s, 31'd0};
      unpack(a, ma, ea);
      unpack(b, mb, eb);
      return round_f32(s, ma * mb, ea + eb);
    endfunction

    function logic [31:0] fp_add(logic [31:0] a, logic [31:0] b, bit negate_b);
      logic [63:0] ma, mb, big, sml, sum, tm;
      int ea, eb, d, k, te;
      logic sa, sb_, ts, rs;
      if (is_nan(a)) return a | FP_QBIT;
      if (is_nan(b)) return b | FP_QBIT;
      if (negate_b) b[31] = ~b[31];
      if (is_inf(a) && is_inf(b) && a[31] != b[31]) return FP_DNAN;
      if (is_inf(a)) return a;
      if (is_inf(b)) return b;
      if (is_zero(a) && is_zero(b)) return {a[31] & b[31], 31'd0};
      if (is_zero(a)) return b;
      if (is_zero(b)) return a;
      unpack(a, ma, ea);
      unpack(b, mb, eb);
      sa = a[31];
      sb_ = b[31];
      if (eb > ea) begin
        tm = ma; ma = mb; mb = tm;
        te = ea; ea = eb; eb = te;
        ts = sa; sa = sb_; sb_ = ts;
      end
      d = ea - eb;
      big = ma << 30;
      if (d <= 30) begin
        sml = mb << (30 - d);
      end else begin
        k = d - 30;
        if (k >= 64) sml = {63'd0, mb != 0};
        else sml = (mb >> k) | {63'd0, (mb & ((64'd1 << k) - 64'd1)) != 0};
      end
      if (sa == sb_) begin
        sum = big + sml;
        rs = sa;
      end else if (big >= sml) begin
        sum = big - sml;
        rs = sa;
      end else begin
        sum = sml - big;
        rs = sb_;
      end
      if (sum == 0) return 32'd0;
      return round_f32(rs, sum, ea - 30);
    endfunction

    function logic [31:0] fp_div(logic [31:0] a, logic [31:0] b);
      logic [63:0] ma, mb, q, r;
      int ea, eb;
      logic s;
      s = a[31] ^ b[31];
      if (is_zero(b)) begin
        if (is_nan(a)) return a | FP_QBIT;
        if (is_zero(a)) return FP_DNAN;
        return {s, 8'hFF, 23'd0};
      end
      if (is_nan(a)) return a | FP_QBIT;
      if (is_nan(b)) return b | FP_QBIT;
      if (is_inf(a) && is_inf(b)) return FP_DNAN;
      if (is_inf(a)) return {s, 8'hFF, 23'd0};
      if (is_inf(b) || is_zero(a)) return {s, 31'd0};
      unpack(a, ma, ea);
      unpack(b, mb, eb);
      while (!ma[23]) begin
        ma = ma << 1;
        ea--;
      end
      while (!mb[23]) begin
        mb = mb << 1;
        eb--;
      end
      q = (ma << 40) / mb;
      r = (ma << 40) % mb;
      return round_f32(s, (q << 1) | {63'd0, r != 0}, ea - eb - 41);
    endfunction

    function logic [31:0] fp_sqrt(logic [31:0] a);
      longint unsigned m, n, res, bt;
      int e;
      if (a[30:23] == 8'hFF) begin
        if (a[22:0] != 0) return a | FP_QBIT;
        return a[31] ? FP_DNAN : a;
      end
      if (is_zero(a)) return a;
      if (a[31]) return FP_DNAN;
      if (a[30:23] == 8'd0) begin
        e = -126;
        m = a[22:0];
        while (m[23] == 1'b0) begin
          m = m << 1;
          e--;
        end
      end else begin
        e = int'(a[30:23]) - 127;
        m = {41'd0, 1'b1, a[22:0]};
      end
      if ((e & 1) != 0) begin
        m = m << 1;
        e = e - 1;
      end
      n = m << 23;
      res = 0;
      bt = 64'd1 << 46;
      while (bt != 0) begin
        if (n >= res + bt) begin
          n = n - (res + bt);
          res = (res >> 1) + bt;
        end else begin
          res = res >> 1;
        end
        bt = bt >> 2;
      end
      if (n > res) res++;
      e = e / 2 + 127;
      if (res >= (64'd1 << 24)) begin
        res = res >> 1;
        e++;
      end
      return {1'b0, 8'(e), res[22:0]};
    endfunction

    function void note_word(logic md, logic [11:0] idx, logic [31:0] g, logic fs,
                            logic [31:0] lp, logic [31:0] lf, logic [31:0] ls);
      logic [31:0] f1, f2, nb1, nb2, m, mh, d, s, sh, den, step, x;
      param_word_t w;
      if (md == MODE_LOAD) begin
        param_mem[idx] = lp;
        first_mem[idx] = lf;
        second_mem[idx] = ls;
        x = lp;
      end else begin
        if (fs) begin
          pow1 = fp_mul(pow1, beta1);
          pow2 = fp_mul(pow2, beta2);
        end
        f1 = fp_div(FP_ONE, fp_add(FP_ONE, pow1, 1));
        f2 = fp_div(FP_ONE, fp_add(FP_ONE, pow2, 1));
        nb1 = fp_add(FP_ONE, beta1, 1);
        nb2 = fp_add(FP_ONE, beta2, 1);
        m = fp_add(fp_mul(beta1, first_mem[idx]), fp_mul(nb1, g), 1);
        mh = fp_mul(m, f1);
        d = fp_add(g, m, 0);
        s = fp_add(fp_mul(beta2, second_mem[idx]), fp_mul(fp_mul(nb2, d), d), 0);
        sh = fp_mul(s, f2);
        den = fp_add(fp_sqrt(sh), eps, 0);
        step = fp_mul(fp_div(eta, den), mh);
        x = fp_add(param_mem[idx], step, 1);
        first_mem[idx] = m;
        second_mem[idx] = s;
        param_mem[idx] = x;
      end
      w.index = idx;
      w.value = x;
      pending_q.push_back(w);
    endfunction

    function void fail(string what);
      errors++;
      if (errors <= 10) $display("ERROR at %0t: %s", $time, what);
    endfunction

    function void check_word(logic [11:0] idx, logic [31:0] val);
      param_word_t w;
      if (pending_q.size() == 0) begin
        fail($sformatf("unexpected word index %0d param %h", idx, val));
        return;
      end
      w = pending_q.pop_front();
      if (idx !== w.index)
        fail($sformatf("out_index expected %0d got %0d", w.index, idx));
      if (val !== w.value)
        fail($sformatf("param_bits index %0d expected %h got %h", w.index, w.value, val));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic        mode = MODE_UPDATE;
  logic [11:0] elem_index = '0;
  logic [31:0] grad_bits = '0;
  logic        first_of_step = 1'b0;
  logic [31:0] load_param_bits = '0;
  logic [31:0] load_first_bits = '0;
  logic [31:0] load_second_bits = '0;
  logic        done;
  logic [11:0] out_index;
  logic [31:0] param_bits;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = CFG_BETA1;
  logic [31:0] cfg_data = '0;

  update_scoreboard sb = new();
  bit no_idle = 1'b0;
  int idle_cycles = 0;

  adabelief_param_update i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .mode(mode),
    .elem_index(elem_index), .grad_bits(grad_bits), .first_of_step(first_of_step),
    .load_param_bits(load_param_bits), .load_first_bits(load_first_bits),
    .load_second_bits(load_second_bits), .done(done), .out_index(out_index),
    .param_bits(param_bits), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && done) sb.check_word(out_index, param_bits);
  end

  always @(posedge clk) begin
    if (rst || done || (start && !busy) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("adabelief_param_update: mismatch");
        $finish;
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 40) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(30, 80);
  endfunction

  function automatic logic [31:0] rand_float();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return $urandom();
    if (r == 1) begin
      case ($urandom_range(0, 5))
        0: return 32'h7F80_0000;
        1: return 32'hFF80_0000;
        2: return 32'h8000_0000;
        3: return 32'h0000_0001;
        4: return 32'h7F7F_FFFF;
        default: return 32'h7FC0_0000;
      endcase
    end
    return {1'($urandom_range(0, 1)), 8'($urandom_range(110, 135)), 23'($urandom())};
  endfunction

  task automatic send_word(logic md, logic [11:0] idx, logic [31:0] g, logic fs,
                           logic [31:0] lp, logic [31:0] lf, logic [31:0] ls);
    int n;
    n = pick_gap();
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
    mode <= md;
    elem_index <= idx;
    grad_bits <= g;
    first_of_step <= fs;
    load_param_bits <= lp;
    load_first_bits <= lf;
    load_second_bits <= ls;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    sb.note_word(md, idx, g, fs, lp, lf, ls);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_regs(logic [31:0] b1, logic [31:0] b2, logic [31:0] lr,
                            logic [31:0] st);
    logic [31:0] vals [4];
    vals = '{b1, b2, lr, st};
    for (int i = 0; i < 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= 2'(i);
      cfg_data <= vals[i];
      do @(posedge clk); while (!cfg_ready);
      sb.set_reg(2'(i), vals[i]);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic random_items(int count, bit wide_index);
    int k, r, n;
    logic [11:0] idx;
    k = 0;
    while (k < count) begin
      r = $urandom_range(0, 99);
      if (r < 80) begin
        n = $urandom_range(1, 6);
        for (int j = 0; j < n; j++) begin
          idx = wide_index ? 12'($urandom()) : 12'($urandom_range(0, 15));
          send_word(MODE_UPDATE, idx, rand_float(), j == 0, $urandom(), $urandom(),
                    $urandom());
        end
        k += n;
      end else if (r < 92) begin
        idx = wide_index ? 12'($urandom()) : 12'($urandom_range(0, 15));
        send_word(MODE_LOAD, idx, $urandom(), 1'($urandom_range(0, 1)), rand_float(),
                  rand_float(), rand_float());
        k++;
      end else begin
        send_word(1'($urandom_range(0, 1)), 12'($urandom()), $urandom(),
                  1'($urandom_range(0, 1)), $urandom(), $urandom(), $urandom());
        k++;
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    send_word(MODE_UPDATE, 12'd0, 32'h0000_0000, 1'b0, '0, '0, '0);
    send_word(MODE_LOAD, 12'd0, '1, 1'b1, 32'h3F80_0000, 32'h0000_0000, 32'h0000_0000);
    send_word(MODE_UPDATE, 12'd0, 32'h3F80_0000, 1'b1, '0, '0, '0);
    send_word(MODE_UPDATE, 12'd0, 32'hBF80_0000, 1'b0, '0, '0, '0);
    send_word(MODE_LOAD, 12'd4095, '0, 1'b0, '1, '1, '1);
    send_word(MODE_UPDATE, 12'd4095, 32'h0000_0000, 1'b0, '0, '0, '0);
    send_word(MODE_LOAD, 12'd1, '0, 1'b0, 32'h7F7F_FFFF, 32'h8000_0000, 32'h8000_0000);
    send_word(MODE_UPDATE, 12'd1, 32'h0000_0001, 1'b0, '0, '0, '0);
    send_word(MODE_LOAD, 12'd2, '0, 1'b0, 32'h0000_0000, 32'h0000_0000, 32'hBF80_0000);
    send_word(MODE_UPDATE, 12'd2, 32'h3F00_0000, 1'b0, '0, '0, '0);
    send_word(MODE_UPDATE, 12'd3, 32'h7F80_0000, 1'b0, '0, '0, '0);
    send_word(MODE_UPDATE, 12'd4, 32'hFF80_0000, 1'b0, '0, '0, '0);
    send_word(MODE_UPDATE, 12'd5, 32'h7F7F_FFFF, 1'b1, '0, '0, '0);
    send_word(MODE_UPDATE, 12'd6, 32'h8000_0000, 1'b0, '0, '0, '0);
    send_word(MODE_UPDATE, 12'd7, 32'h007F_FFFF, 1'b0, '0, '0, '0);
    send_word(MODE_UPDATE, 12'd2048, 32'hFFFF_FFFF, 1'b1, '0, '0, '0);
    send_word(MODE_LOAD, 12'd100, '0, 1'b0, 32'h3F80_0000, 32'h3DCC_CCCD, 32'h3C23_D70A);
    send_word(MODE_UPDATE, 12'd100, 32'h3E80_0000, 1'b0, '0, '0, '0);
    send_word(MODE_UPDATE, 12'd100, 32'hBE80_0000, 1'b1, '0, '0, '0);
    drain();

    write_regs(32'h3F4C_CCCD, 32'h3F7F_7CEE, 32'h3A83_126F, 32'h2EDB_E6FF);
    random_items(300, 1'b0);
    drain();
    write_regs(BETA1_RESET, BETA2_RESET, ETA_RESET, EPS_RESET);
    random_items(100, 1'b1);
    no_idle = 1'b1;
    random_items(100, 1'b0);
    no_idle = 1'b0;
    drain();
    write_regs(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    random_items(80, 1'b1);
    drain();
    write_regs(32'h3F80_0000, 32'h3F80_0000, 32'h3F80_0000, 32'h0000_0001);
    random_items(60, 1'b0);
    drain();
    write_regs(32'h7F7F_FFFF, 32'h7F7F_FFFF, 32'h7F7F_FFFF, 32'h7F7F_FFFF);
    random_items(60, 1'b0);
    drain();
    write_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    random_items(60, 1'b1);
    drain();

    repeat (20) @(posedge clk);
    if (sb.pending_q.size() != 0) sb.fail("results still pending at the end");
    if (sb.errors == 0) begin
      $display("adabelief_param_update: match");
    end else begin
      $display("adabelief_param_update: mismatch");
    end
    $finish;
  end
endmodule

// ===== files.f =====
sv/adab_pkg.sv
sv/adab_ram.sv
sv/adab_fpu.sv
sv/adabelief_param_update.sv
test/testbench.sv
